### sv/json_string_utf8_escaper_assert.svh
// assertion macros shared by the escaper checker
`ifndef JSON_STRING_UTF8_ESCAPER_ASSERT_SVH
`define JSON_STRING_UTF8_ESCAPER_ASSERT_SVH

// same-cycle implication, off during reset
`define JSE_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define JSE_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error(msg);

// checks what reset leaves behind
`define JSE_ASSERT_RST(lbl, ck, rn, cons, msg) \
  lbl: assert property (@(posedge ck) !(rn) |=> (cons)) \
    else $error(msg);

`endif

### sv/jse_pkg.sv
// types, constants and helpers shared by the escaper modules
`default_nettype none

package jse_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       first_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic       bad_sequence;
    logic       end_of_text;
  } out_item_t;

  typedef enum logic [2:0] {
    BK_NONE,
    BK_CHAR,
    BK_ESC,
    BK_UESC1,
    BK_UESC2,
    BK_ERR
  } body_kind_t;

  // order matters: results of one job come out in this order
  typedef enum logic [2:0] {
    PH_ERR1  = 3'd0,
    PH_OPEN  = 3'd1,
    PH_BODY  = 3'd2,
    PH_ERR2  = 3'd3,
    PH_CLOSE = 3'd4
  } phase_t;

  localparam int NUM_PHASES = 5;

  // everything one input item asks the back end to emit
  typedef struct packed {
    logic        err_open;
    logic        quote_open;
    body_kind_t  kind;
    logic [7:0]  ch;
    logic [15:0] val0;
    logic [15:0] val1;
    logic        err_close;
    logic        quote_close;
  } job_t;

  localparam logic [7:0]  CH_QUOTE     = 8'h22;
  localparam logic [7:0]  CH_BSLASH    = 8'h5c;
  localparam logic [7:0]  CH_SLASH     = 8'h2f;
  localparam logic [7:0]  CH_U         = 8'h75;
  localparam logic [15:0] HI_SURR_OFS  = 16'hd800 - 16'(32'h10000 >> 10);
  localparam logic [15:0] LO_SURR_BASE = 16'hdc00;
  localparam logic [2:0]  LAST_DIGIT   = 3'd5;

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] c;
    if (n < 4'd10) begin
      c = 8'h30 + {4'b0, n};
    end else begin
      c = 8'h57 + {4'b0, n};
    end
    return c;
  endfunction

  // second char of a two-char escape, zero when the byte is not escaped
  function automatic logic [7:0] escape_char(input logic [7:0] b);
    logic [7:0] e;
    case (b)
      CH_QUOTE:  e = CH_QUOTE;
      CH_BSLASH: e = CH_BSLASH;
      CH_SLASH:  e = CH_SLASH;
      8'h08:     e = 8'h62;
      8'h0c:     e = 8'h66;
      8'h0a:     e = 8'h6e;
      8'h0d:     e = 8'h72;
      8'h09:     e = 8'h74;
      default:   e = 8'h00;
    endcase
    return e;
  endfunction

  function automatic phase_t first_phase(input logic [NUM_PHASES-1:0] v);
    phase_t p;
    p = PH_ERR1;
    for (int i = NUM_PHASES - 1; i >= 0; i--) begin
      if (v[i]) begin
        p = phase_t'(3'(i));
      end
    end
    return p;
  endfunction

endpackage

`default_nettype wire

### sv/jse_front.sv
// front end: utf-8 lead byte decode and job classification
`default_nettype none

module jse_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             take,
  input  wire jse_pkg::in_item_t item,
  output jse_pkg::job_t         job,
  output logic                  job_vld
);

  logic [1:0]  pend_r, pend_nxt;
  logic [20:0] cp_r, cp_nxt;

  logic [1:0]  pend_a, pend_b;
  logic [20:0] cp_a, cp_b, cp_acc;
  logic [7:0]  esc;
  logic [7:0]  b;

  always_comb begin
    b       = item.data_byte;
    job     = '0;
    job.kind = jse_pkg::BK_NONE;
    esc     = jse_pkg::escape_char(b);
    cp_acc  = {cp_r[14:0], b[5:0]};

    // a new string drops whatever sequence was left open
    job.err_open   = item.first_byte && (pend_r != 2'd0);
    job.quote_open = item.first_byte;
    pend_a = item.first_byte ? 2'd0 : pend_r;
    cp_a   = item.first_byte ? 21'd0 : cp_r;
    cp_acc = {cp_a[14:0], b[5:0]};

    pend_b = pend_a;
    cp_b   = cp_a;
    if (item.has_byte) begin
      if (pend_a != 2'd0) begin
        pend_b = pend_a - 2'd1;
        if (pend_b == 2'd0) begin
          cp_b = 21'd0;
          if (cp_acc[20:7] == 14'd0) begin
            job.kind = jse_pkg::BK_CHAR;
            job.ch   = cp_acc[7:0];
          end else if (cp_acc[20:16] != 5'd0) begin
            job.kind = jse_pkg::BK_UESC2;
            job.val0 = {5'b0, cp_acc[20:10]} + jse_pkg::HI_SURR_OFS;
            job.val1 = {6'b0, cp_acc[9:0]} + jse_pkg::LO_SURR_BASE;
          end else begin
            job.kind = jse_pkg::BK_UESC1;
            job.val0 = cp_acc[15:0];
          end
        end else begin
          cp_b = cp_acc;
        end
      end else if (esc != 8'h00) begin
        job.kind = jse_pkg::BK_ESC;
        job.ch   = esc;
      end else if (!b[7]) begin
        job.kind = jse_pkg::BK_CHAR;
        job.ch   = b;
      end else if (b[7:5] == 3'b110) begin
        cp_b   = {16'b0, b[4:0]};
        pend_b = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        cp_b   = {17'b0, b[3:0]};
        pend_b = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
        cp_b   = {18'b0, b[2:0]};
        pend_b = 2'd3;
      end else begin
        job.kind = jse_pkg::BK_ERR;
      end
    end

    job.err_close   = item.last_byte && (pend_b != 2'd0);
    job.quote_close = item.last_byte;
    pend_nxt = item.last_byte ? 2'd0 : pend_b;
    cp_nxt   = item.last_byte ? 21'd0 : cp_b;

    job_vld = item.first_byte || item.last_byte || (job.kind != jse_pkg::BK_NONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 2'd0;
      cp_r   <= 21'd0;
    end else if (take) begin
      pend_r <= pend_nxt;
      cp_r   <= cp_nxt;
    end
  end

endmodule

`default_nettype wire

### sv/jse_queue.sv
// short job queue between front and back end
`default_nettype none

module jse_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr_en,
  input  wire jse_pkg::job_t wr_job,
  output logic               full,
  input  wire logic          rd_en,
  output jse_pkg::job_t      rd_job,
  output logic               empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  jse_pkg::job_t mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;

  assign full   = (cnt_r == CW'(DEPTH));
  assign empty  = (cnt_r == '0);
  assign rd_job = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) begin
        wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + AW'(1);
      end
      if (rd_en) begin
        rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + AW'(1);
      end
      if (wr_en && !rd_en) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (rd_en && !wr_en) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

### sv/jse_back.sv
// back end: walks one job a result per cycle into the output register while that register is free or popped
`default_nettype none

module jse_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire jse_pkg::job_t q_job,
  input  wire logic          q_empty,
  output logic               q_rd,
  output jse_pkg::out_item_t out_item,
  output logic               empty,
  input  wire logic          pop
);

  jse_pkg::job_t   cur_r, cur_nxt;
  logic            cur_vld_r, cur_vld_nxt;
  jse_pkg::phase_t ph_r, ph_nxt;
  logic [2:0]      dig_r, dig_nxt;
  logic            hi_r, hi_nxt;

  jse_pkg::out_item_t out_r, res;
  logic               out_vld_r;

  logic                            out_rdy, emit, body_done, phase_last, job_end;
  logic [jse_pkg::NUM_PHASES-1:0]  act_cur, after;
  logic [15:0]                     uval;
  logic [3:0]                      nib;

  function automatic logic [jse_pkg::NUM_PHASES-1:0] active(input jse_pkg::job_t j);
    return {j.quote_close, j.err_close, (j.kind != jse_pkg::BK_NONE),
            j.quote_open, j.err_open};
  endfunction

  assign out_rdy = !out_vld_r || pop;
  assign emit    = cur_vld_r && out_rdy;
  assign act_cur = active(cur_r);
  assign after   = act_cur & (5'b11110 << ph_r);

  always_comb begin
    case (cur_r.kind)
      jse_pkg::BK_ESC:   body_done = (dig_r == 3'd1);
      jse_pkg::BK_UESC1: body_done = (dig_r == jse_pkg::LAST_DIGIT);
      jse_pkg::BK_UESC2: body_done = (dig_r == jse_pkg::LAST_DIGIT) && hi_r;
      default:           body_done = 1'b1;
    endcase
  end

  assign phase_last = (ph_r != jse_pkg::PH_BODY) || body_done;
  assign job_end    = phase_last && (after == '0);

  // next state
  always_comb begin
    cur_nxt     = cur_r;
    cur_vld_nxt = cur_vld_r;
    ph_nxt      = ph_r;
    dig_nxt     = dig_r;
    hi_nxt      = hi_r;
    q_rd        = 1'b0;
    if (emit) begin
      if (!phase_last) begin
        if (dig_r == jse_pkg::LAST_DIGIT) begin
          dig_nxt = 3'd0;
          hi_nxt  = 1'b1;
        end else begin
          dig_nxt = dig_r + 3'd1;
        end
      end else if (!job_end) begin
        ph_nxt  = jse_pkg::first_phase(after);
        dig_nxt = 3'd0;
        hi_nxt  = 1'b0;
      end
    end
    // next job loads in the cycle the current one finishes
    if (!cur_vld_r || (emit && job_end)) begin
      if (!q_empty) begin
        q_rd        = 1'b1;
        cur_nxt     = q_job;
        cur_vld_nxt = 1'b1;
        ph_nxt      = jse_pkg::first_phase(active(q_job));
        dig_nxt     = 3'd0;
        hi_nxt      = 1'b0;
      end else begin
        cur_vld_nxt = 1'b0;
      end
    end
  end

  // result for the current position
  always_comb begin
    uval = hi_r ? cur_r.val1 : cur_r.val0;
    case (dig_r)
      3'd2:    nib = uval[15:12];
      3'd3:    nib = uval[11:8];
      3'd4:    nib = uval[7:4];
      default: nib = uval[3:0];
    endcase
    res = '0;
    res.char_valid = 1'b1;
    case (ph_r)
      jse_pkg::PH_OPEN: begin
        res.out_char = jse_pkg::CH_QUOTE;
      end
      jse_pkg::PH_CLOSE: begin
        res.out_char    = jse_pkg::CH_QUOTE;
        res.end_of_text = 1'b1;
      end
      jse_pkg::PH_BODY: begin
        case (cur_r.kind)
          jse_pkg::BK_CHAR: begin
            res.out_char = cur_r.ch;
          end
          jse_pkg::BK_ESC: begin
            res.out_char = (dig_r == 3'd0) ? jse_pkg::CH_BSLASH : cur_r.ch;
          end
          jse_pkg::BK_UESC1, jse_pkg::BK_UESC2: begin
            case (dig_r)
              3'd0:    res.out_char = jse_pkg::CH_BSLASH;
              3'd1:    res.out_char = jse_pkg::CH_U;
              default: res.out_char = jse_pkg::hex_char(nib);
            endcase
          end
          default: begin
            res.char_valid   = 1'b0;
            res.bad_sequence = 1'b1;
          end
        endcase
      end
      default: begin
        res.char_valid   = 1'b0;
        res.bad_sequence = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
      ph_r      <= jse_pkg::PH_ERR1;
      dig_r     <= 3'd0;
      hi_r      <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      cur_vld_r <= cur_vld_nxt;
      ph_r      <= ph_nxt;
      dig_r     <= dig_nxt;
      hi_r      <= hi_nxt;
      if (emit) begin
        out_vld_r <= 1'b1;
      end else if (pop) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (emit) begin
      out_r <= res;
    end
  end

  assign out_item = out_r;
  assign empty    = !out_vld_r;

endmodule

`default_nettype wire

### sv/json_string_utf8_escaper.sv
// Turns a UTF-8 byte stream into quoted JSON text, one character per result item.
// An item enters every cycle while full is low; the back end then emits one result
// per cycle while the output register is free or popped. An item makes one result for a plain
// byte, two for a short escape, six for a \uXXXX escape, twelve for a surrogate
// pair, plus one for each quote and each error result. The job queue
// (QUEUE_DEPTH entries) absorbs bursts of expansion; full rises only when it fills.
// With the back end idle, an accepted item passes through the job queue and the
// current-job register before its result is registered in out_item.
`default_nettype none

module json_string_utf8_escaper #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  output logic                    full,
  input  wire jse_pkg::in_item_t  in_item,
  output logic                    empty,
  input  wire logic               pop,
  output jse_pkg::out_item_t      out_item
);

  jse_pkg::job_t fe_job, q_job;
  logic          fe_job_vld, take, q_full, q_empty, q_rd;

  assign take = push && !q_full;
  assign full = q_full;

  jse_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .item    (in_item),
    .job     (fe_job),
    .job_vld (fe_job_vld)
  );

  jse_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (take && fe_job_vld),
    .wr_job (fe_job),
    .full   (q_full),
    .rd_en  (q_rd),
    .rd_job (q_job),
    .empty  (q_empty)
  );

  jse_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_job    (q_job),
    .q_empty  (q_empty),
    .q_rd     (q_rd),
    .out_item (out_item),
    .empty    (empty),
    .pop      (pop)
  );

endmodule

`default_nettype wire

### sv/jse_checker.sv
// port-level checks for the escaper, bound to the top level
`default_nettype none

`include "json_string_utf8_escaper_assert.svh"

module jse_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               empty,
  input wire logic               pop,
  input wire jse_pkg::out_item_t out_item
);

  `JSE_ASSERT_RST(a_rst_empty, clk, rst_n, empty, "output not empty after reset")

  `JSE_ASSERT_NXT(a_hold, clk, rst_n, !empty && !pop, !empty && $stable(out_item), "stalled item changed")

  `JSE_ASSERT_IMP(a_kind, clk, rst_n, !empty, out_item.char_valid ^ out_item.bad_sequence, "item neither char nor error")

  `JSE_ASSERT_IMP(a_close, clk, rst_n, !empty && out_item.end_of_text, out_item.char_valid && (out_item.out_char == jse_pkg::CH_QUOTE), "end of text not a quote")

  `JSE_ASSERT_IMP(a_err, clk, rst_n, !empty && out_item.bad_sequence, (out_item.out_char == 8'h00) && !out_item.end_of_text, "error item carries data")

endmodule

bind json_string_utf8_escaper jse_checker u_jse_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .empty    (empty),
  .pop      (pop),
  .out_item (out_item)
);

`default_nettype wire

### dv/json_string_utf8_escaper_checker.sv
// watches both queues of the escaper, predicts the json text and compares it
`timescale 1ns / 100ps

module json_string_utf8_escaper_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  logic               full,
  input  jse_pkg::in_item_t  in_item,
  input  logic               empty,
  input  logic               pop,
  input  jse_pkg::out_item_t out_item,
  output int                 mismatches,
  output int                 outstanding
);

  localparam logic [7:0] ESC_BS  = "b";
  localparam logic [7:0] ESC_FF  = "f";
  localparam logic [7:0] ESC_LF  = "n";
  localparam logic [7:0] ESC_CR  = "r";
  localparam logic [7:0] ESC_TAB = "t";

  logic [1:0]         cont_left;
  logic [20:0]        code_acc;
  jse_pkg::out_item_t text_q[$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
    cont_left   = 2'd0;
    code_acc    = '0;
  end

  function automatic logic [7:0] nibble_ascii(input logic [3:0] n);
    logic [7:0] c;
    if (n > 4'd9) begin
      c = "a" + 8'(n - 4'd10);
    end else begin
      c = "0" + 8'(n);
    end
    return c;
  endfunction

  function void queue_result(input logic [7:0] c, input logic v, input logic bad,
                             input logic eot);
    jse_pkg::out_item_t r;
    r.out_char     = c;
    r.char_valid   = v;
    r.bad_sequence = bad;
    r.end_of_text  = eot;
    text_q.push_back(r);
  endfunction

  function void queue_hex16(input logic [15:0] v);
    queue_result(jse_pkg::CH_BSLASH, 1'b1, 1'b0, 1'b0);
    queue_result(jse_pkg::CH_U, 1'b1, 1'b0, 1'b0);
    for (int i = 3; i >= 0; i--) begin
      queue_result(nibble_ascii(v[i*4 +: 4]), 1'b1, 1'b0, 1'b0);
    end
  endfunction

  function void queue_code_point(input logic [20:0] cp);
    logic [20:0] hi;
    logic [20:0] lo;
    hi = (cp >> 10) + 21'h00d7c0;
    lo = (cp & 21'h0003ff) + 21'h00dc00;
    if (cp < 21'd128) begin
      // overlong forms land here and go out raw
      queue_result(cp[7:0], 1'b1, 1'b0, 1'b0);
    end else if (cp > 21'h00ffff) begin
      queue_hex16(hi[15:0]);
      queue_hex16(lo[15:0]);
    end else begin
      queue_hex16(cp[15:0]);
    end
  endfunction

  // abandon a half-read multi-byte sequence
  function void drop_sequence();
    if (cont_left != 2'd0) begin
      queue_result(8'h00, 1'b0, 1'b1, 1'b0);
      cont_left = 2'd0;
      code_acc  = '0;
    end
  endfunction

  function void escape_byte(input logic [7:0] b);
    logic [7:0] esc;
    esc = 8'h00;
    if (cont_left != 2'd0) begin
      // anything counts as a continuation byte here
      code_acc  = {code_acc[14:0], b[5:0]};
      cont_left = cont_left - 2'd1;
      if (cont_left == 2'd0) begin
        queue_code_point(code_acc);
        code_acc = '0;
      end
    end else begin
      case (b)
        jse_pkg::CH_QUOTE, jse_pkg::CH_BSLASH, jse_pkg::CH_SLASH: esc = b;
        8'h08:   esc = ESC_BS;
        8'h0c:   esc = ESC_FF;
        8'h0a:   esc = ESC_LF;
        8'h0d:   esc = ESC_CR;
        8'h09:   esc = ESC_TAB;
        default: esc = 8'h00;
      endcase
      if (esc != 8'h00) begin
        queue_result(jse_pkg::CH_BSLASH, 1'b1, 1'b0, 1'b0);
        queue_result(esc, 1'b1, 1'b0, 1'b0);
      end else if (!b[7]) begin
        queue_result(b, 1'b1, 1'b0, 1'b0);
      end else if (b[7:5] == 3'b110) begin
        code_acc  = {16'b0, b[4:0]};
        cont_left = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        code_acc  = {17'b0, b[3:0]};
        cont_left = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
        code_acc  = {18'b0, b[2:0]};
        cont_left = 2'd3;
      end else begin
        queue_result(8'h00, 1'b0, 1'b1, 1'b0);
      end
    end
  endfunction

  function void escape_item(input jse_pkg::in_item_t it);
    if (it.first_byte) begin
      drop_sequence();
      queue_result(jse_pkg::CH_QUOTE, 1'b1, 1'b0, 1'b0);
    end
    if (it.has_byte) begin
      escape_byte(it.data_byte);
    end
    if (it.last_byte) begin
      drop_sequence();
      queue_result(jse_pkg::CH_QUOTE, 1'b1, 1'b0, 1'b1);
    end
  endfunction

  always @(posedge clk) begin
    jse_pkg::out_item_t want;
    if (!rst_n) begin
      cont_left = 2'd0;
      code_acc  = '0;
      text_q.delete();
    end else begin
      if (push && !full) begin
        escape_item(in_item);
      end
      if (pop && !empty) begin
        if (text_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, actual %h/%b/%b/%b",
                   $time, out_item.out_char, out_item.char_valid,
                   out_item.bad_sequence, out_item.end_of_text);
        end else begin
          want = text_q.pop_front();
          if (out_item.out_char !== want.out_char ||
              out_item.char_valid !== want.char_valid ||
              out_item.bad_sequence !== want.bad_sequence ||
              out_item.end_of_text !== want.end_of_text) begin
            mismatches++;
            $display("%0t: mismatch, expected %h/%b/%b/%b, actual %h/%b/%b/%b",
                     $time, want.out_char, want.char_valid, want.bad_sequence,
                     want.end_of_text, out_item.out_char, out_item.char_valid,
                     out_item.bad_sequence, out_item.end_of_text);
          end
        end
      end
    end
    outstanding = text_q.size();
  end

endmodule

### dv/json_string_utf8_escaper_test.sv
// top of the escaper testbench: clock, reset, byte stimulus and the verdict
`timescale 1ns / 100ps

module json_string_utf8_escaper_test;

  localparam int NUM_ITEMS   = 370;
  localparam int CYCLE_LIMIT = 200000;

  logic               clk     = 1'b0;
  logic               rst_n   = 1'b0;
  logic               push    = 1'b0;
  logic               pop     = 1'b0;
  jse_pkg::in_item_t  in_item = '0;
  logic               full;
  logic               empty;
  jse_pkg::out_item_t out_item;
  int                 mismatches;
  int                 outstanding;
  int                 sent    = 0;
  int                 cycle_cnt = 0;
  logic               steady  = 1'b0;
  logic [7:0]         str_bytes[$];

  json_string_utf8_escaper i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

  json_string_utf8_escaper_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .full        (full),
    .in_item     (in_item),
    .empty       (empty),
    .pop         (pop),
    .out_item    (out_item),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // result side stalls at random except during the steady stretch
  initial begin
    forever begin
      @(posedge clk);
      pop <= rst_n && (steady || $urandom_range(0, 99) >= 21);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic has, input logic first,
                           input logic last);
    jse_pkg::in_item_t it;
    it.data_byte  = b;
    it.has_byte   = has;
    it.first_byte = first;
    it.last_byte  = last;
    steady = (sent >= 150) && (sent < 230);
    while (!steady && $urandom_range(0, 99) < 21) begin
      push <= 1'b0;
      @(posedge clk);
    end
    in_item <= it;
    push    <= 1'b1;
    @(posedge clk);
    while (full) begin
      @(posedge clk);
    end
    sent++;
  endtask

  task automatic send_string();
    if (str_bytes.size() == 0) begin
      send_byte(8'h00, 1'b0, 1'b1, 1'b1);
    end else begin
      for (int i = 0; i < str_bytes.size(); i++) begin
        send_byte(str_bytes[i], 1'b1, i == 0, i == str_bytes.size() - 1);
      end
    end
  endtask

  // mostly clean continuation bytes, now and then an arbitrary one
  function automatic logic [7:0] cont_byte();
    logic [7:0] b;
    if ($urandom_range(0, 7) == 0) begin
      b = 8'($urandom_range(0, 255));
    end else begin
      b = 8'h80 | 8'($urandom_range(0, 63));
    end
    return b;
  endfunction

  task automatic add_char();
    int kind;
    logic [7:0] escapes[8];
    escapes = '{8'h22, 8'h5c, 8'h2f, 8'h08, 8'h0c, 8'h0a, 8'h0d, 8'h09};
    kind = $urandom_range(0, 9);
    case (kind)
      4: str_bytes.push_back(escapes[$urandom_range(0, 7)]);
      5: begin
        str_bytes.push_back(8'hc0 | 8'($urandom_range(0, 31)));
        str_bytes.push_back(cont_byte());
      end
      6: begin
        str_bytes.push_back(8'he0 | 8'($urandom_range(0, 15)));
        repeat (2) str_bytes.push_back(cont_byte());
      end
      7, 8: begin
        str_bytes.push_back(8'hf0 | 8'($urandom_range(0, 7)));
        repeat (3) str_bytes.push_back(cont_byte());
      end
      9: begin
        // bad lead byte or a lead byte with nothing after it
        if ($urandom_range(0, 1) == 1) begin
          str_bytes.push_back(8'h80 | 8'($urandom_range(0, 63)));
        end else begin
          str_bytes.push_back(8'hc0 | 8'($urandom_range(0, 63)));
        end
      end
      default: str_bytes.push_back(8'($urandom_range(0, 127)));
    endcase
  endtask

  initial begin
    int nchars;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed items
    send_byte(8'h00, 1'b0, 1'b1, 1'b1);  // empty string
    send_byte(8'h22, 1'b1, 1'b1, 1'b0);
    send_byte(8'h5c, 1'b1, 1'b0, 1'b0);
    send_byte(8'h08, 1'b1, 1'b0, 1'b0);
    send_byte(8'h00, 1'b1, 1'b0, 1'b0);
    send_byte(8'h7f, 1'b1, 1'b0, 1'b0);
    send_byte(8'hc3, 1'b1, 1'b0, 1'b0);
    send_byte(8'ha9, 1'b1, 1'b0, 1'b0);
    // largest four-byte value, surrogate pair with no range check
    send_byte(8'hf7, 1'b1, 1'b0, 1'b0);
    send_byte(8'hbf, 1'b1, 1'b0, 1'b0);
    send_byte(8'hbf, 1'b1, 1'b0, 1'b0);
    send_byte(8'hbf, 1'b1, 1'b0, 1'b0);
    // overlong form whose continuation is a quote
    send_byte(8'hc1, 1'b1, 1'b0, 1'b0);
    send_byte(8'h22, 1'b1, 1'b0, 1'b0);
    send_byte(8'hff, 1'b1, 1'b0, 1'b0);
    send_byte(8'h80, 1'b1, 1'b0, 1'b0);
    send_byte(8'he2, 1'b1, 1'b0, 1'b1);  // cut short by the string end
    send_byte(8'h00, 1'b0, 1'b0, 1'b0);  // no byte, no flags
    send_byte(8'hf0, 1'b1, 1'b1, 1'b0);
    send_byte(8'h90, 1'b1, 1'b0, 1'b0);
    send_byte(8'h41, 1'b1, 1'b1, 1'b0);  // cut short by a new string
    send_byte(8'h00, 1'b0, 1'b0, 1'b1);
    send_byte(8'hc2, 1'b1, 1'b0, 1'b0);  // outside any string
    send_byte(8'h80, 1'b1, 1'b1, 1'b1);

    while (sent < NUM_ITEMS) begin
      if ($urandom_range(0, 99) < 20) begin
        repeat ($urandom_range(1, 4)) begin
          send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
      end else begin
        str_bytes.delete();
        nchars = $urandom_range(0, 8);
        repeat (nchars) add_char();
        send_string();
      end
    end
    push <= 1'b0;
    steady = 1'b0;

    // let the checker take in the last item before trusting its count
    @(posedge clk);
    while (outstanding != 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### json_string_utf8_escaper.f
+incdir+sv
sv/jse_pkg.sv
sv/jse_front.sv
sv/jse_queue.sv
sv/jse_back.sv
sv/json_string_utf8_escaper.sv
sv/jse_checker.sv
dv/json_string_utf8_escaper_checker.sv
dv/json_string_utf8_escaper_test.sv
